// ===== src/psh_pkg.sv =====
package psh_pkg;

    localparam int PARTIAL_CAP = 80;

    localparam int IDX_W  = 7;
    localparam int POS_W  = 17;
    localparam int GAIN_W = 17;
    localparam int MODE_W = 3;
    localparam int CNT_W  = 7;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // divider geometry: numerator, denominator and quotient widths
    localparam int NUM_W = 48;
    localparam int DEN_W = 24;
    localparam int QUO_W = 32;
    localparam int EXT_W = DEN_W + QUO_W;

    localparam logic [GAIN_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [GAIN_W-1:0] HALF_Q16 = 17'h08000;

    localparam logic [MODE_W-1:0] MODE_ROLLOFF  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOWPASS  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BANDPASS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOTCH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COMB     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NARROW   = 3'd6;

    localparam logic [1:0] REG_SHAPE_MODE    = 2'd0;
    localparam logic [1:0] REG_PARTIAL_COUNT = 2'd1;
    localparam logic [1:0] REG_SLOPE_WIDTH   = 2'd2;

    localparam logic [1:0] KIND_QUO   = 2'd0;
    localparam logic [1:0] KIND_COMB  = 2'd1;
    localparam logic [1:0] KIND_CONST = 2'd2;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(PARTIAL_CAP)) begin
            r = CNT_W'(PARTIAL_CAP);
        end
        return r;
    endfunction

endpackage

// ===== src/partial_amplitude_shaper.sv =====
// Gain of one partial of an additive voice, unsigned Q1.16. One beat in, one
// beat out; a new beat can be taken every cycle while the skid is empty. An input
// beat passes through four front stages (capture and position saturation,
// centre and products, distance and rolloff product, divide operands), then a
// 32-stage restoring divider that yields one quotient bit per stage, then the
// output register. A two-entry output (register plus skid) keeps s_tready free
// of m_tready. Registers sit at byte addresses 0, 4, 8 and should only be
// written while no beat is in flight.
module partial_amplitude_shaper import psh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // partial_index[6:0], position[23:7]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // gain[16:0], zero pad
);

    logic [MODE_W-1:0] shape_mode_reg;
    logic [CNT_W-1:0]  partial_count_reg;
    logic [CNT_W-1:0]  slope_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode_reg    <= MODE_COMB;
            partial_count_reg <= CNT_W'(30);
            slope_width_reg   <= CNT_W'(7);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SHAPE_MODE:    shape_mode_reg    <= pwdata[MODE_W-1:0];
                REG_PARTIAL_COUNT: partial_count_reg <= pwdata[CNT_W-1:0];
                REG_SLOPE_WIDTH:   slope_width_reg   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SHAPE_MODE:    prdata = DATA_W'(shape_mode_reg);
            REG_PARTIAL_COUNT: prdata = DATA_W'(partial_count_reg);
            REG_SLOPE_WIDTH:   prdata = DATA_W'(slope_width_reg);
            default:           prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    logic [CNT_W-1:0] np;
    logic [CNT_W-1:0] w;
    assign np = clamp_count(partial_count_reg);
    assign w  = clamp_count(slope_width_reg);

    logic skid_v_reg;
    logic en;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    // stage 1: capture, position saturated to one
    logic [POS_W-1:0] p_in;
    logic             v1_reg;
    logic [IDX_W-1:0] i1_reg;
    logic [POS_W-1:0] p1_reg;
    assign p_in = s_tdata[IDX_W +: POS_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            i1_reg <= s_tdata[IDX_W-1:0];
            p1_reg <= (p_in > ONE_Q16) ? ONE_Q16 : p_in;
        end
    end

    // stage 2: centre, comb products, rolloff slope and distance
    logic [DEN_W-1:0]  c_s2;
    logic [13:0]       ip_s2;
    logic [DEN_W-1:0]  wp_s2;
    logic [17:0]       p2x;
    logic [17:0]       k_wide;
    logic              half;
    logic [IDX_W-1:0]  d_s2;

    assign c_s2   = DEN_W'(p1_reg) * DEN_W'(np);
    assign ip_s2  = 14'(i1_reg) * (14'(i1_reg) + 14'd2);
    assign wp_s2  = DEN_W'(p1_reg) * DEN_W'(w);
    assign p2x    = {p1_reg, 1'b0};
    assign half   = p1_reg <= HALF_Q16;
    assign k_wide = half ? (18'(ONE_Q16) - p2x) : (p2x - 18'(ONE_Q16));
    assign d_s2   = half ? i1_reg : ((np > i1_reg) ? (np - CNT_W'(1) - i1_reg) : '0);

    logic              v2_reg;
    logic [IDX_W-1:0]  i2_reg;
    logic [DEN_W-1:0]  c2_reg;
    logic [13:0]       ip2_reg;
    logic [DEN_W-1:0]  wp2_reg;
    logic [GAIN_W-1:0] k2_reg;
    logic [IDX_W-1:0]  d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            i2_reg  <= i1_reg;
            c2_reg  <= c_s2;
            ip2_reg <= ip_s2;
            wp2_reg <= wp_s2;
            k2_reg  <= k_wide[GAIN_W-1:0];
            d2_reg  <= d_s2;
        end
    end

    // stage 3: signed distance from centre, rolloff denominator product
    logic [DEN_W-1:0] is_s3;
    logic             below_s3;
    logic [DEN_W-1:0] at_s3;
    logic [DEN_W-1:0] dk_s3;

    assign is_s3    = DEN_W'({i2_reg, 16'b0});
    assign below_s3 = is_s3 < c2_reg;
    assign at_s3    = below_s3 ? (c2_reg - is_s3) : (is_s3 - c2_reg);
    assign dk_s3    = DEN_W'(d2_reg) * DEN_W'(k2_reg);

    logic             v3_reg;
    logic [IDX_W-1:0] i3_reg;
    logic [13:0]      ip3_reg;
    logic [DEN_W-1:0] wp3_reg;
    logic [DEN_W-1:0] dk3_reg;
    logic [DEN_W-1:0] at3_reg;
    logic             below3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            i3_reg     <= i2_reg;
            ip3_reg    <= ip2_reg;
            wp3_reg    <= wp2_reg;
            dk3_reg    <= dk_s3;
            at3_reg    <= at_s3;
            below3_reg <= below_s3;
        end
    end

    // stage 4: divide operands per mode; num is pre-biased by den/2 for rounding
    logic [DEN_W-1:0] ws;
    logic             over;
    logic [NUM_W-1:0] comb_n0;
    logic [NUM_W-1:0] num_s4;
    logic [DEN_W-1:0] den_s4;
    logic [1:0]       kind_s4;
    logic             full_s4;

    assign ws   = DEN_W'({w, 16'b0});
    assign over = at3_reg > ws;

    always_comb begin
        num_s4  = '0;
        den_s4  = DEN_W'(1);
        kind_s4 = KIND_CONST;
        full_s4 = 1'b0;
        comb_n0 = '0;
        case (shape_mode_reg)
            MODE_ROLLOFF: begin
                den_s4  = dk3_reg + DEN_W'(ONE_Q16);
                num_s4  = (NUM_W'(1) << 32) + NUM_W'(den_s4 >> 1);
                kind_s4 = KIND_QUO;
            end
            MODE_LOWPASS, MODE_BANDPASS: begin
                if (below3_reg && shape_mode_reg == MODE_LOWPASS) begin
                    full_s4 = 1'b1;
                end else if (!over) begin
                    num_s4  = NUM_W'(ws - at3_reg) + NUM_W'(w >> 1);
                    den_s4  = DEN_W'(w);
                    kind_s4 = KIND_QUO;
                end
            end
            MODE_HIGHPASS, MODE_NOTCH: begin
                if (below3_reg && shape_mode_reg == MODE_HIGHPASS) begin
                    full_s4 = 1'b0;
                end else if (over) begin
                    full_s4 = 1'b1;
                end else begin
                    num_s4  = NUM_W'(at3_reg) + NUM_W'(w >> 1);
                    den_s4  = DEN_W'(w);
                    kind_s4 = KIND_QUO;
                end
            end
            MODE_COMB: begin
                comb_n0 = (NUM_W'(i3_reg) << 16) + (NUM_W'(wp3_reg) << 1);
                num_s4  = (comb_n0 << 16) + (NUM_W'(w) << 15);
                den_s4  = ws;
                kind_s4 = KIND_COMB;
            end
            MODE_NARROW: begin
                comb_n0 = (NUM_W'(ip3_reg) << 16) + (NUM_W'(wp3_reg) << 2);
                num_s4  = (comb_n0 << 16) + (NUM_W'(w) << 16);
                den_s4  = ws << 1;
                kind_s4 = KIND_COMB;
            end
            default: ;
        endcase
    end

    // restoring divider, one quotient bit per stage
    logic             dv_reg   [0:QUO_W];
    logic [NUM_W-1:0] rem_reg  [0:QUO_W];
    logic [DEN_W-1:0] den_reg  [0:QUO_W];
    logic [QUO_W-1:0] quo_reg  [0:QUO_W];
    logic [1:0]       kind_reg [0:QUO_W];
    logic             full_reg [0:QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num_s4;
            den_reg[0]  <= den_s4;
            quo_reg[0]  <= '0;
            kind_reg[0] <= kind_s4;
            full_reg[0] <= full_s4;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_div
        logic [EXT_W-1:0] shifted;
        logic             ge;
        logic [EXT_W-1:0] diff;

        assign shifted = EXT_W'(den_reg[s]) << (QUO_W - 1 - s);
        assign ge      = EXT_W'(rem_reg[s]) >= shifted;
        assign diff    = EXT_W'(rem_reg[s]) - shifted;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[s+1] <= 1'b0;
            end else if (en) begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1]  <= ge ? diff[NUM_W-1:0] : rem_reg[s];
                den_reg[s+1]  <= den_reg[s];
                quo_reg[s+1]  <= {quo_reg[s][QUO_W-2:0], ge};
                kind_reg[s+1] <= kind_reg[s];
                full_reg[s+1] <= full_reg[s];
            end
        end
    end

    // result: quotient clamp, triangle from fraction and integer parity, or constant
    logic [QUO_W-1:0]  qf;
    logic [GAIN_W-1:0] frac;
    logic [GAIN_W-1:0] gain_post;
    logic              arrive;

    assign qf     = quo_reg[QUO_W];
    assign frac   = {1'b0, qf[15:0]};
    assign arrive = en && dv_reg[QUO_W];

    always_comb begin
        case (kind_reg[QUO_W])
            KIND_QUO:  gain_post = (qf > QUO_W'(ONE_Q16)) ? ONE_Q16 : qf[GAIN_W-1:0];
            KIND_COMB: gain_post = qf[16] ? frac : (ONE_Q16 - frac);
            default:   gain_post = full_reg[QUO_W] ? ONE_Q16 : '0;
        endcase
    end

    logic              m_valid_reg;
    logic [GAIN_W-1:0] m_gain_reg;
    logic [GAIN_W-1:0] skid_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_v_reg) begin
                m_valid_reg <= 1'b1;
                skid_v_reg  <= 1'b0;
            end else begin
                m_valid_reg <= arrive;
            end
        end else if (arrive) begin
            skid_v_reg <= 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            m_gain_reg <= skid_v_reg ? skid_gain_reg : gain_post;
        end else if (arrive) begin
            skid_gain_reg <= gain_post;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_gain_reg);

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(skid_v_reg) |-> m_valid_reg)
        else $error("skid drained without loading the output register");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_gain_reg <= ONE_Q16))
        else $error("gain above one");

endmodule
